// ===== rtl/psmv_pkg.sv =====
// ----------------------------------------------------------------------------
// psmv_pkg
// Shared widths, entry type and helpers of the persistent stack version store.
// ----------------------------------------------------------------------------
package psmv_pkg;

  localparam int MAX_VERSIONS = 262144;
  localparam int VER_W        = 18;
  localparam int PUSH_W       = 16;
  localparam int MASS_W       = 34;
  localparam int SUM_W        = 63;
  localparam int ADDR_W       = $clog2(MAX_VERSIONS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int CMP_W        = (CNT_W > VER_W) ? CNT_W : VER_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_VERSIONS);

  // one stored version: what lies below the top, empty flag, total mass
  typedef struct packed {
    logic [VER_W-1:0]  link;
    logic              empty;
    logic [MASS_W-1:0] mass;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{link: '0, empty: 1'b1, mass: '0};

  // finished operation handed from the sequencer to the output side
  typedef struct packed {
    logic [VER_W-1:0]  new_version;
    logic [MASS_W-1:0] version_mass;
    logic              bad;
  } result_t;

  function automatic logic [ADDR_W-1:0] ver_to_addr(input logic [VER_W-1:0] v);
    logic [CMP_W-1:0] t;
    t = CMP_W'(v);
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [VER_W-1:0] cnt_to_ver(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] t;
    t = CMP_W'(c);
    return t[VER_W-1:0];
  endfunction

  function automatic logic ver_below(input logic [VER_W-1:0] v,
                                     input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(v);
    b = CMP_W'(c);
    return a < b;
  endfunction

endpackage

// ===== rtl/psmv_if.sv =====
// ----------------------------------------------------------------------------
// psmv_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface psmv_in_if import psmv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [VER_W-1:0]  base_version;
  logic [PUSH_W-1:0] push_mass;

  modport source (output valid, base_version, push_mass, input ready);
  modport sink   (input valid, base_version, push_mass, output ready);
endinterface

interface psmv_out_if import psmv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [VER_W-1:0]  new_version;
  logic [MASS_W-1:0] version_mass;
  logic [SUM_W-1:0]  running_total;
  logic              bad_request;

  modport source (output valid, new_version, version_mass, running_total,
                  bad_request, input ready);
  modport sink   (input valid, new_version, version_mass, running_total,
                  bad_request, output ready);
endinterface

// ===== rtl/psmv_store.sv =====
// ----------------------------------------------------------------------------
// psmv_store
// Version entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psmv_store import psmv_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [MAX_VERSIONS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/psmv_seq.sv =====
// ----------------------------------------------------------------------------
// psmv_seq
// Operation sequencer: reads the base entry, for a pop of a non-empty version
// the entry beneath, builds the new entry and writes it at the next free version.
// ----------------------------------------------------------------------------
module psmv_seq import psmv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VER_W-1:0]  in_base,
  input  logic [PUSH_W-1:0] in_mass,
  input  logic              out_free,
  output logic              done,
  output result_t           result,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  entry_t            rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output entry_t            wr_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BASE   = 2'd1;
  localparam logic [1:0] S_UNDER  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [VER_W-1:0]  base_r;
  logic [PUSH_W-1:0] mass_r;
  logic              bad_r;
  logic              zero_r;
  entry_t            ent_r;
  entry_t            rd_ent;
  logic              accept;
  logic              req_bad;
  logic [MASS_W:0]   push_sum;
  logic [MASS_W-1:0] push_total;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign req_bad  = (count_r == CNT_FULL) || !ver_below(in_base, count_r);

  // entry zero is never written; it reads as the empty stack
  assign rd_ent = zero_r ? ENTRY_EMPTY : rd_data;

  assign push_sum   = {1'b0, rd_ent.mass} + (MASS_W + 1)'(mass_r);
  assign push_total = push_sum[MASS_W] ? '1 : push_sum[MASS_W-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ver_to_addr(in_base);
    case (state_r)
      S_IDLE: begin
        rd_en = accept;
      end
      S_BASE: begin
        rd_addr = ver_to_addr(rd_ent.link);
        rd_en   = (mass_r == '0) && !rd_ent.empty;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = req_bad ? S_FINISH : S_BASE;
        end
      end
      S_BASE: begin
        if ((mass_r != '0) || rd_ent.empty) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_UNDER;
        end
      end
      S_UNDER: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign wr_en   = done && !bad_r;
  assign wr_addr = count_r[ADDR_W-1:0];
  assign wr_data = ent_r;

  assign result.new_version  = bad_r ? '0 : cnt_to_ver(count_r);
  assign result.version_mass = bad_r ? '0 : ent_r.mass;
  assign result.bad          = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      zero_r <= (rd_addr == '0);
    end
    if (accept) begin
      base_r <= in_base;
      mass_r <= in_mass;
      bad_r  <= req_bad;
    end
    if (state_r == S_BASE) begin
      if (mass_r != '0) begin
        ent_r.link  <= base_r;
        ent_r.empty <= 1'b0;
        ent_r.mass  <= push_total;
      end else if (rd_ent.empty) begin
        ent_r <= ENTRY_EMPTY;
      end
    end
    if (state_r == S_UNDER) begin
      ent_r <= rd_ent;
    end
  end

endmodule

// ===== rtl/persistent_stack_mass_versions_unit.sv =====
// ----------------------------------------------------------------------------
// persistent_stack_mass_versions_unit
// Versioned stack of masses: each transaction derives one new version from
// an existing one by a push or a pop; results carry a saturating mass sum.
// ----------------------------------------------------------------------------
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | base_version[17:0], push_mass[15:0]
//   out_ch   | out | new_version[17:0], version_mass[33:0],
//            |     | running_total[62:0], bad_request
//
// one operation at a time: a rejected request goes from acceptance straight
// to the final step, a push or a pop of an empty version reads the base entry
// first, a pop of a non-empty version also the entry beneath its top, as the
// reads of the entry memory are chained; a new in_ch transaction is accepted
// only once the result of the last one has been handed on.
// the result waits in an output register; a stalled out_ch holds the
// sequencer in its final step until the register frees.
// rst_n (synchronous) restores the single empty version zero and a zero sum;
// no clearing pass, since only versions already created are ever used.
module persistent_stack_mass_versions_unit import psmv_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  psmv_in_if.sink        in_ch,
  psmv_out_if.source     out_ch
);

  logic              out_free;
  logic              done;
  result_t           result;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              out_valid_r;
  logic [VER_W-1:0]  out_version_r;
  logic [MASS_W-1:0] out_mass_r;
  logic [SUM_W-1:0]  out_total_r;
  logic              out_bad_r;
  logic [SUM_W-1:0]  mass_sum_r, mass_sum_nxt;
  logic [SUM_W:0]    sum_wide;

  assign out_free = !out_valid_r || out_ch.ready;

  psmv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_base  (in_ch.base_version),
    .in_mass  (in_ch.push_mass),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  psmv_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // saturating running sum, untouched by rejected requests
  assign sum_wide = {1'b0, mass_sum_r} + (SUM_W + 1)'(result.version_mass);

  always_comb begin
    mass_sum_nxt = mass_sum_r;
    if (!result.bad) begin
      mass_sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mass_sum_r  <= '0;
    end else begin
      if (done) begin
        out_valid_r <= 1'b1;
        mass_sum_r  <= mass_sum_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_version_r <= result.new_version;
      out_mass_r    <= result.version_mass;
      out_total_r   <= mass_sum_nxt;
      out_bad_r     <= result.bad;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_version   = out_version_r;
  assign out_ch.version_mass  = out_mass_r;
  assign out_ch.running_total = out_total_r;
  assign out_ch.bad_request   = out_bad_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the persistent stack version store. A short table
// of pushes, pops and rejected requests comes first, then random traffic
// aimed at deep stacks with random stalls on both channels, then a few
// closing requests. Every result is checked field by field: typed table rows
// against their own values, others against a behavioral model of the entries.
// ----------------------------------------------------------------------------
module tb;
  import psmv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF       = 200;
  localparam int HOLD_AT        = 400;
  localparam int RANDOM_OPS     = 1400;
  localparam int MAX_REPORTS    = 30;

  localparam logic [PUSH_W-1:0] POP       = '0;
  localparam logic [VER_W-1:0]  TOP_VER   = '1;
  localparam logic [MASS_W-1:0] MASS_CEIL = '1;
  localparam logic [SUM_W-1:0]  SUM_CEIL  = '1;

  typedef struct packed {
    logic [VER_W-1:0]  new_version;
    logic [MASS_W-1:0] version_mass;
    logic [SUM_W-1:0]  running_total;
    logic              bad;
  } outcome_t;

  typedef struct packed {
    logic [VER_W-1:0]  base;
    logic [PUSH_W-1:0] mass;
    logic              typed;
    logic [VER_W-1:0]  ver;
    logic [MASS_W-1:0] vmass;
    logic [SUM_W-1:0]  total;
    logic              bad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  psmv_in_if  in_ch ();
  psmv_out_if out_ch ();

  persistent_stack_mass_versions_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // model of the version entries
  logic [VER_W-1:0]  link_mem  [MAX_VERSIONS];
  logic              empty_mem [MAX_VERSIONS];
  logic [MASS_W-1:0] mass_mem  [MAX_VERSIONS];
  logic [CNT_W-1:0]  ver_cnt;
  logic [SUM_W-1:0]  sum_acc;

  outcome_t pending_results [$];
  int       mismatch_cnt = 0;
  int       results_seen = 0;
  int       idle_cycles  = 0;
  bit       calm         = 1'b0;

  // typed rows carry their result; the others are left to the model
  dir_row_t dir_rows [21] = '{
    {18'd1,      16'd5,      1'b1, 18'd0,  34'd0,      63'd0,      1'b1},
    {TOP_VER,    16'hFFFF,   1'b1, 18'd0,  34'd0,      63'd0,      1'b1},
    {18'd0,      POP,        1'b1, 18'd1,  34'd0,      63'd0,      1'b0},
    {18'd1,      16'hFFFF,   1'b1, 18'd2,  34'd65535,  63'd65535,  1'b0},
    {18'd2,      16'd1,      1'b1, 18'd3,  34'd65536,  63'd131071, 1'b0},
    {18'd3,      POP,        1'b1, 18'd4,  34'd65535,  63'd196606, 1'b0},
    {18'd4,      POP,        1'b1, 18'd5,  34'd0,      63'd196606, 1'b0},
    {18'd5,      POP,        1'b1, 18'd6,  34'd0,      63'd196606, 1'b0},
    {18'd6,      16'hAAAA,   1'b1, 18'd7,  34'd43690,  63'd240296, 1'b0},
    {18'd7,      16'h5555,   1'b1, 18'd8,  34'd65535,  63'd305831, 1'b0},
    {18'd8,      16'hFFFF,   1'b1, 18'd9,  34'd131070, 63'd436901, 1'b0},
    {18'd9,      POP,        1'b1, 18'd10, 34'd65535,  63'd502436, 1'b0},
    {18'd10,     POP,        1'b1, 18'd11, 34'd43690,  63'd546126, 1'b0},
    {18'd11,     POP,        1'b1, 18'd12, 34'd0,      63'd546126, 1'b0},
    {18'd12,     16'h8000,   1'b1, 18'd13, 34'd32768,  63'd578894, 1'b0},
    {18'd14,     16'd3,      1'b1, 18'd0,  34'd0,      63'd578894, 1'b1},
    {18'd3,      POP,        1'b1, 18'd14, 34'd65535,  63'd644429, 1'b0},
    {18'h20000,  16'd7,      1'b1, 18'd0,  34'd0,      63'd644429, 1'b1},
    {18'd0,      16'd1,      1'b1, 18'd15, 34'd1,      63'd644430, 1'b0},
    {18'd15,     16'h1234,   1'b0, 18'd0,  34'd0,      63'd0,      1'b0},
    {18'd14,     POP,        1'b0, 18'd0,  34'd0,      63'd0,      1'b0}
  };

  function automatic outcome_t apply_op(input logic [VER_W-1:0]  base,
                                        input logic [PUSH_W-1:0] mass);
    outcome_t          r;
    logic [VER_W-1:0]  slot;
    logic [VER_W-1:0]  under;
    logic [MASS_W:0]   grown;
    logic [MASS_W-1:0] nm;
    logic [SUM_W:0]    sum_next;
    r = '0;
    r.running_total = sum_acc;
    if (ver_cnt >= CNT_FULL || CNT_W'(base) >= ver_cnt) begin
      r.bad = 1'b1;
      return r;
    end
    slot = ver_cnt[VER_W-1:0];
    if (mass != POP) begin
      grown = mass_mem[base] + mass;
      nm = grown[MASS_W] ? MASS_CEIL : grown[MASS_W-1:0];
      link_mem[slot]  = base;
      empty_mem[slot] = 1'b0;
      mass_mem[slot]  = nm;
    end else if (empty_mem[base]) begin
      nm = '0;
      link_mem[slot]  = '0;
      empty_mem[slot] = 1'b1;
      mass_mem[slot]  = '0;
    end else begin
      // the new version is the one left under the base's top
      under = link_mem[base];
      if (CNT_W'(under) >= ver_cnt) under = '0;
      nm = mass_mem[under];
      link_mem[slot]  = link_mem[under];
      empty_mem[slot] = empty_mem[under];
      mass_mem[slot]  = nm;
    end
    ver_cnt = ver_cnt + 1'b1;
    sum_next = sum_acc + nm;
    sum_acc = (sum_next > {1'b0, SUM_CEIL}) ? SUM_CEIL : sum_next[SUM_W-1:0];
    r.new_version   = slot;
    r.version_mass  = nm;
    r.running_total = sum_acc;
    return r;
  endfunction

  task automatic send_op(input logic [VER_W-1:0] base, input logic [PUSH_W-1:0] mass,
                         input int gap, input bit typed, input outcome_t want);
    outcome_t predicted;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.base_version <= base;
    in_ch.push_mass    <= mass;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_op(base, mass);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic send_random(input int gap, input int bad_pct);
    int                pick;
    int                newest;
    logic [VER_W-1:0]  base;
    logic [PUSH_W-1:0] mass;
    newest = int'(ver_cnt) - 1;
    pick = $urandom_range(0, 99);
    if (ver_cnt >= CNT_FULL) begin
      base = VER_W'($urandom);
    end else if (pick < bad_pct) begin
      // a base that does not exist yet
      base = (pick == 0) ? TOP_VER : VER_W'($urandom_range(newest + 1, int'(TOP_VER)));
    end else if (pick < 55) begin
      // stay near the newest versions so stacks grow deep
      base = VER_W'(newest - int'($urandom_range(0, (newest < 15) ? newest : 15)));
    end else begin
      base = VER_W'($urandom_range(0, newest));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) mass = POP;
    else if (pick < 42) mass = '1;
    else if (pick < 46) mass = 16'd1;
    else mass = PUSH_W'($urandom_range(1, 65535));
    send_op(base, mass, gap, 1'b0, '0);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
  endtask

  initial begin : result_sink
    int       gap;
    outcome_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      // one long stall so the block fills up and backs up its input
      if (results_seen == HOLD_AT) gap = HOLD_OFF;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual version %0d",
                   $time, out_ch.new_version);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.new_version !== want.new_version)
          note_mismatch("new_version", 64'(want.new_version), 64'(out_ch.new_version));
        if (out_ch.version_mass !== want.version_mass)
          note_mismatch("version_mass", 64'(want.version_mass), 64'(out_ch.version_mass));
        if (out_ch.running_total !== want.running_total)
          note_mismatch("running_total", 64'(want.running_total),
                        64'(out_ch.running_total));
        if (out_ch.bad_request !== want.bad)
          note_mismatch("bad_request", 64'(want.bad), 64'(out_ch.bad_request));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    outcome_t want;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.base_version <= '0;
    in_ch.push_mass    <= '0;
    ver_cnt      = CNT_W'(1);
    sum_acc      = '0;
    link_mem[0]  = '0;
    empty_mem[0] = 1'b1;
    mass_mem[0]  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row  = dir_rows[i];
      want = {row.ver, row.vmass, row.total, row.bad};
      send_op(row.base, row.mass, $urandom_range(0, 6), row.typed, want);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_OPS / 2) begin
        // sender pause until everything in flight has come back
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      send_random(calm ? 0 : $urandom_range(0, 6), 8);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    calm = 1'b0;
    send_op('0, 16'd9, $urandom_range(0, 6), 1'b0, '0);
    send_op('0, POP, $urandom_range(0, 6), 1'b0, '0);
    repeat (4) send_random($urandom_range(0, 6), 8);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
